[rtl/mdil_pkg.sv]
`timescale 1ns / 1ps
// Package for the multi-dimensional index linearizer.
// Holds the widths, register codes, payload structs and the extent clamp.
// No dependencies.
package mdil_pkg;

    // Dimension count and field widths.
    localparam int NUM_DIMS  = 4;
    localparam int IDX_W     = 12;
    localparam int EXT_W     = IDX_W + 1;
    localparam int CNT_W     = 3;
    localparam int STRIDE_W  = (NUM_DIMS - 1) * IDX_W + 1;
    localparam int OFFSET_W  = 48;
    localparam int TOTAL_W   = 49;

    // Register port geometry.
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Register indexes on the configuration port.
    localparam logic [CNT_W-1:0] REG_DIM_COUNT   = 3'd0;
    localparam logic [CNT_W-1:0] REG_EXTENT_BASE = 3'd1;

    // Largest legal extent.
    localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(1) << IDX_W;

    // Input item.
    typedef struct packed {
        logic [IDX_W-1:0] idx_0;
        logic [IDX_W-1:0] idx_1;
        logic [IDX_W-1:0] idx_2;
        logic [IDX_W-1:0] idx_3;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [OFFSET_W-1:0] flat_offset;
        logic [IDX_W-1:0]    next_0;
        logic [IDX_W-1:0]    next_1;
        logic [IDX_W-1:0]    next_2;
        logic [IDX_W-1:0]    next_3;
        logic                has_next;
        logic [TOTAL_W-1:0]  element_total;
    } out_item_t;

    // Per-lane settings derived from the registers.
    typedef struct packed {
        logic                used;
        logic [EXT_W-1:0]    ext;
        logic [STRIDE_W-1:0] stride;
    } lane_cfg_t;

    // Per-lane registered result handed to the merging stage.
    typedef struct packed {
        logic [OFFSET_W-1:0] prod;
        logic                last;
        logic [IDX_W-1:0]    inc;
        logic [IDX_W-1:0]    idx;
    } lane_res_t;

    // An extent of 0 reads as 1, anything above EXT_MAX saturates to EXT_MAX.
    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        if (e == '0)
            r = EXT_W'(1);
        else if (e > EXT_MAX)
            r = EXT_MAX;
        else
            r = e;
        return r;
    endfunction

endpackage

[rtl/mdil_stride.sv]
`timescale 1ns / 1ps
// Configuration registers and the stride chain of the index linearizer.
// Depends on mdil_pkg.
module mdil_stride (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mdil_pkg::ADDR_W-1:0]   paddr,
    input  logic [mdil_pkg::DATA_W-1:0]   pwdata,
    output logic [mdil_pkg::DATA_W-1:0]   prdata,
    output mdil_pkg::lane_cfg_t [mdil_pkg::NUM_DIMS-1:0] lane_cfg,
    output logic [mdil_pkg::TOTAL_W-1:0]  total,
    output logic                          busy
);
    import mdil_pkg::*;

    localparam int SETTLE_CYCLES = NUM_DIMS + 1;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    logic [CNT_W-1:0]    dim_count_reg;
    logic [EXT_W-1:0]    ext_reg [NUM_DIMS];
    logic [CNT_W-1:0]    dims_used;
    logic [EXT_W-1:0]    eff_ext [NUM_DIMS];
    logic [STRIDE_W-1:0] stride_reg  [NUM_DIMS];
    logic [STRIDE_W-1:0] stride_next [NUM_DIMS];
    logic [TOTAL_W-1:0]  total_reg;
    logic [STRIDE_W+EXT_W-1:0] total_prod;
    logic [SETTLE_W-1:0] settle_reg;
    logic                wr_en;
    logic [CNT_W-1:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= CNT_W'(1);
            for (int k = 0; k < NUM_DIMS; k++)
            begin
                ext_reg[k] <= EXT_W'(1);
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_DIM_COUNT)
                dim_count_reg <= pwdata[CNT_W-1:0];
            for (int k = 0; k < NUM_DIMS; k++)
            begin
                if (reg_idx == REG_EXTENT_BASE + CNT_W'(k))
                    ext_reg[k] <= pwdata[EXT_W-1:0];
            end
        end
    end

    // Register reads.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_DIM_COUNT)
            prdata = DATA_W'(dim_count_reg);
        for (int k = 0; k < NUM_DIMS; k++)
        begin
            if (reg_idx == REG_EXTENT_BASE + CNT_W'(k))
                prdata = DATA_W'(ext_reg[k]);
        end
    end

    // A dimension count above the number of lanes saturates.
    assign dims_used = (dim_count_reg > CNT_W'(NUM_DIMS)) ? CNT_W'(NUM_DIMS) : dim_count_reg;

    // Unused dimensions act as extent 1 so that they neither scale nor block the carry.
    always_comb
    begin
        for (int k = 0; k < NUM_DIMS; k++)
        begin
            eff_ext[k] = (CNT_W'(k) < dims_used) ? clamp_ext(ext_reg[k]) : EXT_W'(1);
        end
    end

    // Stride chain: each stride is the next one times the next dimension's extent,
    // one multiplier between neighbouring registers, so the chain settles one dimension a cycle.
    genvar g;
    generate
        for (g = 0; g < NUM_DIMS; g++)
        begin : g_stride
            if (g == NUM_DIMS - 1)
            begin : g_last
                assign stride_next[g] = STRIDE_W'(1);
            end
            else
            begin : g_mul
                logic [STRIDE_W+EXT_W-1:0] prod;
                assign prod           = stride_reg[g+1] * eff_ext[g+1];
                assign stride_next[g] = prod[STRIDE_W-1:0];
            end

            always_ff @(posedge clk)
            begin
                stride_reg[g] <= stride_next[g];
            end

            assign lane_cfg[g].used   = CNT_W'(g) < dims_used;
            assign lane_cfg[g].ext    = eff_ext[g];
            assign lane_cfg[g].stride = stride_reg[g];
        end
    endgenerate

    // Element total from the slowest stride.
    assign total_prod = stride_reg[0] * eff_ext[0];

    always_ff @(posedge clk)
    begin
        total_reg <= total_prod[TOTAL_W-1:0];
    end

    assign total = total_reg;

    // Hold off items until the chain has settled after reset or a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        else if (wr_en)
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        else if (settle_reg != '0)
            settle_reg <= settle_reg - SETTLE_W'(1);
    end

    assign busy = settle_reg != '0;

endmodule

[rtl/mdil_lane.sv]
`timescale 1ns / 1ps
// One lane of the index linearizer: index times stride and the odometer step.
// Depends on mdil_pkg.
module mdil_lane (
    input  logic                        clk,
    input  logic                        load,
    input  logic [mdil_pkg::IDX_W-1:0]  idx,
    input  mdil_pkg::lane_cfg_t         cfg,
    output mdil_pkg::lane_res_t         res
);
    import mdil_pkg::*;

    logic [IDX_W-1:0]          idx_eff;
    logic [EXT_W-1:0]          idx_plus;
    logic [STRIDE_W+IDX_W-1:0] prod;
    lane_res_t                 res_reg;
    lane_res_t                 res_next;

    // An unused dimension contributes index 0.
    assign idx_eff  = cfg.used ? idx : '0;
    assign idx_plus = EXT_W'(idx_eff) + EXT_W'(1);
    assign prod     = idx_eff * cfg.stride;

    // The lane is at its last position when the increment reaches or exceeds the extent.
    always_comb
    begin
        res_next.prod = prod[OFFSET_W-1:0];
        res_next.last = idx_plus >= cfg.ext;
        res_next.inc  = idx_plus[IDX_W-1:0];
        res_next.idx  = idx_eff;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

[rtl/mdil_merge.sv]
`timescale 1ns / 1ps
// Merging stage of the index linearizer: sums the lane products, runs the
// odometer carry and holds the result register. Depends on mdil_pkg.
module mdil_merge (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      lane_valid,
    input  mdil_pkg::lane_res_t [mdil_pkg::NUM_DIMS-1:0] lane_res,
    input  logic [mdil_pkg::TOTAL_W-1:0]              total,
    output logic                                      take,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output mdil_pkg::out_item_t                       out_data
);
    import mdil_pkg::*;

    logic                out_valid_reg;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;
    logic [OFFSET_W-1:0] sum;
    logic [IDX_W-1:0]    nxt [NUM_DIMS];
    logic                carry;

    // The result register can take a new transfer when empty or draining.
    assign take = !out_valid_reg || !out_stall;

    // Sum of the lane products and the carry from the fastest dimension up.
    always_comb
    begin
        sum   = '0;
        carry = 1'b1;
        for (int k = 0; k < NUM_DIMS; k++)
        begin
            sum = sum + lane_res[k].prod;
        end
        for (int k = NUM_DIMS - 1; k >= 0; k--)
        begin
            if (!carry)
                nxt[k] = lane_res[k].idx;
            else if (lane_res[k].last)
                nxt[k] = '0;
            else
                nxt[k] = lane_res[k].inc;
            carry = carry && lane_res[k].last;
        end
        out_data_next.flat_offset   = sum;
        out_data_next.next_0        = nxt[0];
        out_data_next.next_1        = nxt[1];
        out_data_next.next_2        = nxt[2];
        out_data_next.next_3        = nxt[3];
        out_data_next.has_next      = !carry;
        out_data_next.element_total = total;
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= lane_valid;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take && lane_valid)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/multidim_index_linearizer_top.sv]
`timescale 1ns / 1ps
// Multi-dimensional index linearizer, top level: registers, lanes and merge.
// Depends on mdil_pkg, mdil_stride, mdil_lane and mdil_merge.
//
// Turns a row-major index tuple of up to four dimensions into its flat offset,
// the next tuple of an odometer walk with a has_next flag, and the element
// total. One item is accepted per cycle while in_stall is low; its result is
// registered first in the four per-dimension lanes (index times stride) and
// then in the merging stage (offset sum and carry). After reset and after any
// register write, in_stall stays high while the stride chain, with a multiplier
// between neighbouring dimensions, recomputes the strides from the extents.
module multidim_index_linearizer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdil_pkg::ADDR_W-1:0] paddr,
    input  logic [mdil_pkg::DATA_W-1:0] pwdata,
    output logic [mdil_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mdil_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mdil_pkg::out_item_t         out_data
);
    import mdil_pkg::*;

    lane_cfg_t [NUM_DIMS-1:0] lane_cfg;
    lane_res_t [NUM_DIMS-1:0] lane_res;
    logic [IDX_W-1:0]         idx [NUM_DIMS];
    logic [TOTAL_W-1:0]       total;
    logic                     busy;
    logic                     take;
    logic                     lane_valid_reg;
    logic                     lane_load;
    logic                     in_xfer;

    assign pready = 1'b1;

    // Registers and strides.
    mdil_stride u_stride (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .lane_cfg (lane_cfg),
        .total    (total),
        .busy     (busy)
    );

    // The lane stage moves when it is empty or the merge stage takes its contents.
    assign lane_load = !lane_valid_reg || take;
    assign in_stall  = busy || !lane_load;
    assign in_xfer   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_valid_reg <= 1'b0;
        else if (lane_load)
            lane_valid_reg <= in_xfer;
    end

    assign idx[0] = in_data.idx_0;
    assign idx[1] = in_data.idx_1;
    assign idx[2] = in_data.idx_2;
    assign idx[3] = in_data.idx_3;

    // One lane per dimension.
    genvar g;
    generate
        for (g = 0; g < NUM_DIMS; g++)
        begin : g_lane
            mdil_lane u_lane (
                .clk  (clk),
                .load (in_xfer),
                .idx  (idx[g]),
                .cfg  (lane_cfg[g]),
                .res  (lane_res[g])
            );
        end
    endgenerate

    // Merge and result register.
    mdil_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_valid_reg),
        .lane_res   (lane_res),
        .total      (total),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

`ifndef NO_ASSERTIONS
    // No item is taken in the cycle after a register write.
    a_settle_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> in_stall)
        else $error("item accepted while strides settle");

    // A wrapped walk leaves every next component at zero.
    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.has_next) |->
        (out_data.next_0 == '0 && out_data.next_1 == '0 &&
         out_data.next_2 == '0 && out_data.next_3 == '0))
        else $error("wrap with nonzero next tuple");

    // A held result keeps the lane stage occupied.
    a_lane_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid_reg && out_valid && out_stall) |=> lane_valid_reg)
        else $error("lane stage lost an item");

    // The element total is never zero.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.element_total != '0))
        else $error("zero element total");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multidim_index_linearizer_top: directed and random index
// tuples under several register settings, with random idling on both streams.
// Depends on mdil_pkg and the RTL of multidim_index_linearizer_top.
module tb_top;

    import mdil_pkg::*;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          REG_UNMAPPED   = int'(REG_EXTENT_BASE) + NUM_DIMS;
    localparam int          ITEMS_PER_RUN  = 100;
    localparam int          RANDOM_RUNS    = 6;
    localparam logic [63:0] EXT_LIMIT      = 64'(1) << IDX_W;

    // Clock, reset and block ports.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_data;

    // Shadow of the configuration registers as last written.
    logic [CNT_W-1:0]  dims_reg;
    logic [EXT_W-1:0]  extent_reg [NUM_DIMS];

    // Results predicted for accepted tuples, oldest first.
    out_item_t         pending_addr [$];
    out_item_t         last_addr;
    int                error_count  = 0;
    int                idle_cycles  = 0;
    bit                quiet        = 1'b0;

    multidim_index_linearizer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Extent of one dimension as the block reads it: 0 means 1, large values saturate.
    function automatic logic [63:0] effective_extent(input int k);
        logic [63:0] e;
        e = 64'(extent_reg[k]);
        if (e == 0)
            e = 1;
        else if (e > EXT_LIMIT)
            e = EXT_LIMIT;
        return e;
    endfunction

    // Row-major offset, odometer successor and element count for one tuple.
    function automatic out_item_t linearize_index(input in_item_t ix);
        out_item_t        r;
        logic [IDX_W-1:0] idx [NUM_DIMS];
        logic [IDX_W-1:0] nxt [NUM_DIMS];
        logic [63:0]      offset;
        logic [63:0]      stride;
        int               used;
        bit               more;
        idx[0] = ix.idx_0;
        idx[1] = ix.idx_1;
        idx[2] = ix.idx_2;
        idx[3] = ix.idx_3;
        used = (int'(dims_reg) > NUM_DIMS) ? NUM_DIMS : int'(dims_reg);
        offset = 0;
        stride = 1;
        more = 1'b0;
        for (int k = 0; k < NUM_DIMS; k++)
            nxt[k] = (k < used) ? idx[k] : '0;
        // Walk from the fastest dimension, accumulating stride.
        for (int k = used - 1; k >= 0; k--)
        begin
            offset = offset + 64'(idx[k]) * stride;
            stride = stride * effective_extent(k);
        end
        // Increment with carry; an index at or past its end clears and carries.
        for (int k = used - 1; k >= 0 && !more; k--)
        begin
            if (64'(idx[k]) + 1 < effective_extent(k))
            begin
                nxt[k] = idx[k] + 1'b1;
                more = 1'b1;
            end
            else
                nxt[k] = '0;
        end
        r.flat_offset   = offset[OFFSET_W-1:0];
        r.next_0        = nxt[0];
        r.next_1        = nxt[1];
        r.next_2        = nxt[2];
        r.next_3        = nxt[3];
        r.has_next      = more;
        r.element_total = stride[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare every result transfer with the oldest prediction.
    always @(posedge clk)
    begin : addr_checker
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_addr.size() == 0)
            begin
                $display("%0t: result transfer with none expected, actual %0h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_addr.pop_front();
                check_field("flat_offset", 64'(want.flat_offset), 64'(out_data.flat_offset));
                check_field("next_0", 64'(want.next_0), 64'(out_data.next_0));
                check_field("next_1", 64'(want.next_1), 64'(out_data.next_1));
                check_field("next_2", 64'(want.next_2), 64'(out_data.next_2));
                check_field("next_3", 64'(want.next_3), 64'(out_data.next_3));
                check_field("has_next", 64'(want.has_next), 64'(out_data.has_next));
                check_field("element_total", 64'(want.element_total),
                            64'(out_data.element_total));
            end
        end
    end

    // Stall the result stream in random bursts until the quiet part of the run.
    initial
    begin : result_pacing
        wait (rst_n);
        forever
        begin
            out_stall <= !quiet && ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transfer or register access.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one tuple, wait for its transfer and record the predicted result.
    task automatic push_index(input in_item_t item);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        last_addr = linearize_index(item);
        pending_addr.push_back(last_addr);
    endtask

    task automatic push_tuple(input int a, input int b, input int c, input int d);
        in_item_t item;
        item.idx_0 = IDX_W'(a);
        item.idx_1 = IDX_W'(b);
        item.idx_2 = IDX_W'(c);
        item.idx_3 = IDX_W'(d);
        push_index(item);
    endtask

    // Stop offering tuples and let every outstanding result come out.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_addr.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == int'(REG_DIM_COUNT))
            dims_reg = value[CNT_W-1:0];
        else if (index >= int'(REG_EXTENT_BASE) && index < REG_UNMAPPED)
            extent_reg[index - int'(REG_EXTENT_BASE)] = value[EXT_W-1:0];
        @(posedge clk);
    endtask

    // Read a mapped register back and compare with the shadow copy.
    task automatic verify_reg(input int index);
        logic [DATA_W-1:0] want;
        if (index == int'(REG_DIM_COUNT))
            want = DATA_W'(dims_reg);
        else
            want = DATA_W'(extent_reg[index - int'(REG_EXTENT_BASE)]);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_W'(index * 4);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, index, want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Field value with random bits above the register width, now and then.
    function automatic logic [DATA_W-1:0] with_noise(input int field, input int width);
        logic [DATA_W-1:0] upper;
        upper = ($urandom_range(0, 1) == 0) ? '0 : DATA_W'($urandom);
        return (upper & ~((DATA_W'(1) << width) - 1)) | DATA_W'(field);
    endfunction

    task automatic apply_config(input int dims, input int e0, input int e1,
                                input int e2, input int e3);
        drain();
        write_reg(int'(REG_DIM_COUNT), with_noise(dims, CNT_W));
        write_reg(int'(REG_EXTENT_BASE) + 0, with_noise(e0, EXT_W));
        write_reg(int'(REG_EXTENT_BASE) + 1, with_noise(e1, EXT_W));
        write_reg(int'(REG_EXTENT_BASE) + 2, with_noise(e2, EXT_W));
        write_reg(int'(REG_EXTENT_BASE) + 3, with_noise(e3, EXT_W));
        for (int i = 0; i < REG_UNMAPPED; i++)
            verify_reg(i);
    endtask

    // Registers come out of reset as one dimension of extent one.
    task automatic test_reset_values;
        for (int i = 0; i < REG_UNMAPPED; i++)
            verify_reg(i);
        push_tuple(0, 0, 0, 0);
        push_tuple(4095, 4095, 4095, 4095);
    endtask

    // With no dimensions in use everything reads as a single element: offset 0, total 1, no next tuple.
    task automatic test_no_dims;
        apply_config(0, 5, 6, 7, 8);
        push_tuple(123, 4095, 7, 2048);
        push_tuple(0, 0, 0, 0);
    endtask

    // Full four-dimensional shape at the largest extents.
    task automatic test_full_extents;
        apply_config(4, 4096, 4096, 4096, 4096);
        push_tuple(0, 0, 0, 0);
        push_tuple(4095, 4095, 4095, 4095);
        push_tuple(0, 4095, 4095, 4095);
        push_tuple(4095, 0, 0, 4094);
        push_tuple(1, 2, 3, 4);
    endtask

    // Saturating dimension count, extents of zero and above range, unmapped register.
    task automatic test_clamped_config;
        apply_config(7, 0, 8191, 4097, 3);
        push_tuple(0, 4095, 4095, 2);
        push_tuple(0, 0, 0, 5);
        drain();
        write_reg($urandom_range(REG_UNMAPPED, 7), DATA_W'($urandom));
        for (int i = 0; i < REG_UNMAPPED; i++)
            verify_reg(i);
        push_tuple(2222, 17, 4095, 1);
    endtask

    // Indices at or past their extent still count and carry.
    task automatic test_unchecked_indices;
        apply_config(3, 3, 5, 2, 9);
        push_tuple(7, 9, 4095, 100);
        push_tuple(2, 4, 1, 0);
        push_tuple(2, 6, 0, 0);
        push_tuple(0, 4, 3, 4095);
    endtask

    function automatic int pick_extent;
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 4096;
            2:       return $urandom_range(4097, 8191);
            3, 4, 5: return $urandom_range(1, 8);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // One index component, biased toward the last position to exercise carries.
    function automatic int pick_component(input int k);
        int top;
        top = int'(effective_extent(k)) - 1;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 4095);
            2, 3, 4: return top;
            5:       return 0;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // Random shapes; tuples are mostly in range, with odometer walks and stray values.
    task automatic test_random;
        int       walk_left;
        in_item_t item;
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            if (run == 0)
                apply_config(4, 4096, 4096, 4096, 4096);
            else
                apply_config(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(1, 4),
                             pick_extent(), pick_extent(), pick_extent(), pick_extent());
            if (run == RANDOM_RUNS - 1)
                quiet = 1'b1;
            walk_left = 0;
            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                if (walk_left == 0 && n > 0 && $urandom_range(0, 3) == 0)
                    walk_left = $urandom_range(2, 16);
                if (walk_left > 0)
                begin
                    item.idx_0 = last_addr.next_0;
                    item.idx_1 = last_addr.next_1;
                    item.idx_2 = last_addr.next_2;
                    item.idx_3 = last_addr.next_3;
                    walk_left--;
                end
                else
                begin
                    item.idx_0 = IDX_W'(pick_component(0));
                    item.idx_1 = IDX_W'(pick_component(1));
                    item.idx_2 = IDX_W'(pick_component(2));
                    item.idx_3 = IDX_W'(pick_component(3));
                end
                push_index(item);
            end
        end
    endtask

    initial
    begin
        dims_reg = CNT_W'(1);
        for (int i = 0; i < NUM_DIMS; i++)
            extent_reg[i] = EXT_W'(1);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_no_dims();
        test_full_extents();
        test_clamped_config();
        test_unchecked_indices();
        test_random();

        drain();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
